>>> hdl/ipbl_pkg.sv
// Shared constants and types for the IP blocklist table.
// Holds command and status codes, field widths and the controller-to-datapath
// command struct. No dependencies.
`default_nettype none

package ipbl_pkg;

	// Table size default and field widths
	localparam int DEPTH_DEFAULT = 32;
	localparam int ADDR_W        = 32;
	localparam int CMD_W         = 2;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 6;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture the incoming transaction
		logic compare;  // compare the address against every entry
		logic encode;   // reduce the match vector to hit and position
		logic update;   // apply the table change and load the result
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> hdl/ipbl_ctrl.sv
// Controller state machine for the IP blocklist table.
// Sequences capture, compare, encode and update, and owns both handshakes.
// Depends on ipbl_pkg.
`default_nettype none

module ipbl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ipbl_pkg::dp_cmd_t      dp_cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ENC,
		S_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Result register can take a new result when empty or being drained now
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Decode datapath commands from the state
	always_comb begin
		dp_cmd.load    = (state_q == S_IDLE) && in_valid;
		dp_cmd.compare = (state_q == S_CMP);
		dp_cmd.encode  = (state_q == S_ENC);
		dp_cmd.update  = (state_q == S_UPD) && out_free;
	end

	// Advance state and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drain the one that was taken
			if ((state_q == S_UPD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ENC;
				end
				S_ENC: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/ipbl_dp.sv
// Datapath for the IP blocklist table: entry registers, fill count,
// parallel match, position encode and the result register.
// Depends on ipbl_pkg.
`default_nettype none

module ipbl_dp #(
	parameter int DEPTH = ipbl_pkg::DEPTH_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ipbl_pkg::dp_cmd_t              dp_cmd,
	input  wire logic [ipbl_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ipbl_pkg::ADDR_W-1:0]    ip_addr,
	output logic      [ipbl_pkg::STATUS_W-1:0]  status,
	output logic                                drop,
	output logic      [ipbl_pkg::COUNT_W-1:0]   entry_count
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [ipbl_pkg::CMD_W-1:0]    cmd_q;
	logic [ipbl_pkg::ADDR_W-1:0]   addr_q;
	logic [ipbl_pkg::ADDR_W-1:0]   entries_q [DEPTH];
	logic [CW-1:0]                 fill_q;
	logic [DEPTH-1:0]              match_s1;
	logic                          hit_s2;
	logic [IW-1:0]                 pos_s2;
	logic [IW-1:0]                 pos_enc;
	logic                          full;
	logic                          do_add;
	logic                          do_remove;
	logic [CW-1:0]                 fill_next;
	logic [ipbl_pkg::STATUS_W-1:0] status_next;
	logic [ipbl_pkg::STATUS_W-1:0] status_q;
	logic                          drop_q;
	logic [ipbl_pkg::COUNT_W-1:0]  entry_count_q;

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= cmd;
			addr_q <= ip_addr;
		end
	end

	// Compare the address against every valid entry
	always_ff @(posedge clk) begin
		if (dp_cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= (entries_q[i] == addr_q) && (CW'(i) < fill_q);
			end
		end
	end

	// Encode the match position; entries are unique so at most one bit is set
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos_enc = pos_enc | (match_s1[i] ? IW'(i) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.encode) begin
			hit_s2 <= |match_s1;
			pos_s2 <= pos_enc;
		end
	end

	// Decide the table change and the result
	always_comb begin
		full        = (fill_q == CW'(DEPTH));
		do_add      = 1'b0;
		do_remove   = 1'b0;
		status_next = ipbl_pkg::ST_OK;
		fill_next   = fill_q;
		case (cmd_q)
			ipbl_pkg::CMD_ADD: begin
				if (full) begin
					status_next = ipbl_pkg::ST_FULL;
				end else if (!hit_s2) begin
					do_add    = 1'b1;
					fill_next = fill_q + CW'(1);
				end
			end
			ipbl_pkg::CMD_REMOVE: begin
				if (!hit_s2) begin
					status_next = ipbl_pkg::ST_NOTFOUND;
				end else begin
					do_remove = 1'b1;
					fill_next = fill_q - CW'(1);
				end
			end
			default: begin
				status_next = ipbl_pkg::ST_OK;
			end
		endcase
	end

	// Append on add, shift later entries down on remove
	always_ff @(posedge clk) begin
		if (dp_cmd.update) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_add && (IW'(i) == fill_q[IW-1:0])) begin
					entries_q[i] <= addr_q;
				end else if (do_remove && (IW'(i) >= pos_s2) && (i + 1 < DEPTH)) begin
					entries_q[i] <= entries_q[(i + 1 < DEPTH) ? i + 1 : i];
				end
			end
		end
	end

	// Hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (dp_cmd.update) begin
			fill_q <= fill_next;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (dp_cmd.update) begin
			status_q      <= status_next;
			drop_q        <= hit_s2 && (cmd_q == ipbl_pkg::CMD_CHECK);
			entry_count_q <= ipbl_pkg::COUNT_W'(fill_next);
		end
	end

	assign status      = status_q;
	assign drop        = drop_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

>>> hdl/ip_blocklist_table.sv
// Top level of the IP blocklist table: controller plus datapath.
// Depends on ipbl_pkg, ipbl_ctrl and ipbl_dp.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   cmd, ip_addr
//   out      from block out_valid/out_stall status, drop, entry_count
//
// Each transaction runs through four steps: capture, compare against all
// entries in parallel, encode the match position, then update the table
// and load the result register. One transaction is in flight at a time.
// Reset clears the fill count; entries need no clearing.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile and waits in its update step until the register frees.
`default_nettype none

module ip_blocklist_table #(
	parameter int DEPTH = ipbl_pkg::DEPTH_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ipbl_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ipbl_pkg::ADDR_W-1:0]    ip_addr,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [ipbl_pkg::STATUS_W-1:0]  status,
	output logic                                drop,
	output logic      [ipbl_pkg::COUNT_W-1:0]   entry_count
);

	ipbl_pkg::dp_cmd_t dp_cmd;

	ipbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	ipbl_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.cmd         (cmd),
		.ip_addr     (ip_addr),
		.status      (status),
		.drop        (drop),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire
